### hw/rtl/bse_pkg.sv
// Package for the battery state-of-charge estimator: item types, opcodes,
// fit coefficients and sizing constants. It depends on nothing else.
package bse_pkg;

    localparam int COEF_FRAC_BITS = 48;
    localparam int CHUNK_W        = 32;
    localparam int NUM_CHUNKS     = (COEF_FRAC_BITS + 40 + CHUNK_W - 1) / CHUNK_W;
    localparam int ACC_W          = NUM_CHUNKS * CHUNK_W;
    localparam int CHUNK_IDX_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int INT_W          = ACC_W - COEF_FRAC_BITS;

    localparam int ADC_W   = 12;
    localparam int SCALE_W = 16;
    localparam int MV_W    = 16;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = ADC_W + SCALE_W + 1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd8192;
    localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_EMPTY   = 7'd0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic       KIND_MEASURE     = 1'b0;
    localparam logic       KIND_RESTORE     = 1'b1;
    localparam logic [1:0] SRC_BATTERY      = 2'd0;
    localparam logic [1:0] SRC_USB_CHARGING = 2'd1;
    localparam logic [1:0] SRC_USB_FULL     = 2'd2;

    localparam logic FIT_DISCHARGE = 1'b0;
    localparam logic FIT_CHARGE    = 1'b1;

    typedef enum logic [1:0] {
        OP_RESTORE,
        OP_DISCHARGE,
        OP_CHARGE,
        OP_FULL
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_MUL,
        BS_FIN
    } t_back_state;

    typedef struct packed {
        logic             kind;
        logic [ADC_W-1:0] adc_millivolts;
        logic [1:0]       power_source;
        logic [PCT_W-1:0] restore_percent;
    } t_in_item;

    typedef struct packed {
        logic [PCT_W-1:0] charge_percent;
        logic [PCT_W-1:0] fitted_percent;
        logic [MV_W-1:0]  battery_millivolts;
        logic             store_request;
    } t_out_item;

    typedef struct packed {
        t_op              op;
        logic [MV_W-1:0]  millivolts;
        logic [PCT_W-1:0] percent;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

    // Coefficient given as mant * 10^-exp10, returned as the nearest multiple
    // of 2^-COEF_FRAC_BITS with ties away from zero. Optionally the rounding
    // half of the final shift is folded in. Used at elaboration only.
    function automatic logic [ACC_W-1:0] coef_fixed(input logic [63:0] mant,
                                                    input int exp10,
                                                    input logic neg,
                                                    input logic add_half);
        logic [127:0]     den;
        logic [127:0]     num;
        logic [127:0]     rem;
        logic [127:0]     quo;
        logic [ACC_W-1:0] val;
        den = 128'd1;
        for (int k = 0; k < exp10; k++) begin
            den = den * 128'd10;
        end
        num = 128'(mant) << COEF_FRAC_BITS;
        rem = '0;
        quo = '0;
        for (int i = 127; i >= 0; i--) begin
            rem = {rem[126:0], num[i]};
            quo = {quo[126:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        if ({rem[126:0], 1'b0} >= den) begin
            quo = quo + 128'd1;
        end
        val = neg ? ACC_W'(~quo + 128'd1) : quo[ACC_W-1:0];
        if (add_half) begin
            val = val + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
        end
        return val;
    endfunction

    // Order per fit: cube, square, linear, constant.
    localparam logic [ACC_W-1:0] FIT_COEF [2][4] = '{
        '{coef_fixed(64'd960793904232693, 21, 1'b1, 1'b0),
          coef_fixed(64'd111898302885909, 16, 1'b0, 1'b0),
          coef_fixed(64'd431825705771347, 13, 1'b1, 1'b0),
          coef_fixed(64'd552635169294168, 10, 1'b0, 1'b1)},
        '{coef_fixed(64'd523052000216911, 23, 1'b1, 1'b0),
          coef_fixed(64'd160622939859106, 19, 1'b1, 1'b0),
          coef_fixed(64'd623432964243526, 15, 1'b0, 1'b0),
          coef_fixed(64'd185443701498477, 11, 1'b1, 1'b1)}
    };

endpackage

### hw/rtl/bse_front.sv
// Front end of the estimator: holds the scale register, accepts items,
// scales the voltage and classifies each item into a job. Uses bse_pkg.
module bse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bse_pkg::SCALE_W-1:0]  i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  bse_pkg::t_in_item            i_data,
    input  bse_pkg::t_queue_status       i_qstat,
    output logic                         o_push,
    output bse_pkg::t_job                o_job
);

    logic [bse_pkg::SCALE_W-1:0] r_scale;
    logic                        r_valid;
    bse_pkg::t_in_item           r_item;

    logic                        accept;
    logic [bse_pkg::PROD_W-1:0]  scaled;
    logic [bse_pkg::MV_W:0]      mv_wide;

    assign o_push  = r_valid && !i_qstat.full;
    assign o_stall = r_valid && !o_push;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= bse_pkg::SCALE_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_data;
        end
    end

    always_comb begin
        scaled  = bse_pkg::PROD_W'(r_item.adc_millivolts) * bse_pkg::PROD_W'(r_scale)
                + bse_pkg::PROD_W'(2048);
        mv_wide = scaled[bse_pkg::PROD_W-1:12];
        o_job.millivolts = mv_wide[bse_pkg::MV_W] ? '1 : mv_wide[bse_pkg::MV_W-1:0];
        o_job.percent    = (r_item.restore_percent > bse_pkg::PCT_FULL)
                         ? bse_pkg::PCT_FULL : r_item.restore_percent;
        priority if (r_item.kind == bse_pkg::KIND_RESTORE) begin
            o_job.op = bse_pkg::OP_RESTORE;
        end else if (r_item.power_source == bse_pkg::SRC_BATTERY) begin
            o_job.op = bse_pkg::OP_DISCHARGE;
        end else if (r_item.power_source == bse_pkg::SRC_USB_FULL) begin
            o_job.op = bse_pkg::OP_FULL;
        end else begin
            o_job.op = bse_pkg::OP_CHARGE;
        end
    end

endmodule

### hw/rtl/bse_queue.sv
// Short job queue between the estimator front end and the fit engine.
// Uses bse_pkg for the job type and depth.
module bse_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bse_pkg::t_job           i_job,
    input  logic                    i_pop,
    output bse_pkg::t_job           o_job,
    output bse_pkg::t_queue_status  o_qstat
);

    bse_pkg::t_job               r_mem [bse_pkg::QUEUE_DEPTH];
    logic [bse_pkg::QPTR_W-1:0]  r_wptr;
    logic [bse_pkg::QPTR_W-1:0]  r_rptr;
    logic [bse_pkg::QCNT_W-1:0]  r_count;

    function automatic logic [bse_pkg::QPTR_W-1:0] ptr_next(
            input logic [bse_pkg::QPTR_W-1:0] ptr);
        return (ptr == bse_pkg::QPTR_W'(bse_pkg::QUEUE_DEPTH - 1))
             ? '0 : bse_pkg::QPTR_W'(ptr + 1'b1);
    endfunction

    assign o_qstat.valid = (r_count != '0);
    assign o_qstat.full  = (r_count == bse_pkg::QCNT_W'(bse_pkg::QUEUE_DEPTH));
    assign o_job         = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

### hw/rtl/bse_back.sv
// Fit engine of the estimator: Horner evaluation on one 32x16 multiplier,
// clamping, kept-charge ratchet and the output register. Uses bse_pkg.
module bse_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bse_pkg::t_queue_status  i_qstat,
    input  bse_pkg::t_job           i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output bse_pkg::t_out_item      o_data
);

    bse_pkg::t_back_state             r_state;
    bse_pkg::t_back_state             n_state;
    bse_pkg::t_job                    r_job;
    logic [bse_pkg::ACC_W-1:0]        r_acc;
    logic [bse_pkg::ACC_W-1:0]        r_prod;
    logic [bse_pkg::CHUNK_IDX_W-1:0]  r_chunk;
    logic [1:0]                       r_step;
    logic [bse_pkg::PCT_W-1:0]        r_kept;
    logic [bse_pkg::PCT_W-1:0]        n_kept;
    logic                             r_out_valid;
    bse_pkg::t_out_item               r_out;
    bse_pkg::t_out_item               n_out;

    logic                                   out_load;
    logic                                   chunk_last;
    logic                                   step_last;
    logic                                   load_fit;
    logic                                   run_fit;
    logic [1:0]                             coef_idx;
    logic [bse_pkg::CHUNK_W-1:0]            acc_chunk;
    logic [bse_pkg::CHUNK_W+bse_pkg::MV_W-1:0] partial;
    logic [bse_pkg::ACC_W-1:0]              n_sum;
    logic [bse_pkg::INT_W-1:0]              whole;
    logic [bse_pkg::PCT_W-1:0]              clamped;
    logic [bse_pkg::PCT_W-1:0]              fit_pct;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bse_pkg::BS_IDLE: begin
                if (i_qstat.valid) begin
                    n_state = (i_job.op == bse_pkg::OP_DISCHARGE ||
                               i_job.op == bse_pkg::OP_CHARGE)
                            ? bse_pkg::BS_MUL : bse_pkg::BS_FIN;
                end
            end
            bse_pkg::BS_MUL: begin
                if (chunk_last && step_last) begin
                    n_state = bse_pkg::BS_FIN;
                end
            end
            bse_pkg::BS_FIN: begin
                if (out_load) begin
                    n_state = bse_pkg::BS_IDLE;
                end
            end
            default: n_state = bse_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = (r_state == bse_pkg::BS_IDLE) && i_qstat.valid;
        out_load   = (r_state == bse_pkg::BS_FIN) && (!r_out_valid || !i_stall);
        chunk_last = (r_chunk == bse_pkg::CHUNK_IDX_W'(bse_pkg::NUM_CHUNKS - 1));
        step_last  = (r_step == 2'd2);
        load_fit   = (i_job.op == bse_pkg::OP_CHARGE);
        run_fit    = (r_job.op == bse_pkg::OP_CHARGE);
        coef_idx   = r_step + 2'd2;
    end

    always_comb begin
        acc_chunk = r_acc[int'(r_chunk) * bse_pkg::CHUNK_W +: bse_pkg::CHUNK_W];
        partial   = (bse_pkg::CHUNK_W + bse_pkg::MV_W)'(acc_chunk)
                  * (bse_pkg::CHUNK_W + bse_pkg::MV_W)'(r_job.millivolts);
        n_sum     = r_prod
                  + (bse_pkg::ACC_W'(partial) << (int'(r_chunk) * bse_pkg::CHUNK_W));
    end

    always_comb begin
        whole = r_acc[bse_pkg::ACC_W-1:bse_pkg::COEF_FRAC_BITS];
        priority if (r_acc[bse_pkg::ACC_W-1]) begin
            clamped = bse_pkg::PCT_EMPTY;
        end else if (whole > bse_pkg::INT_W'(bse_pkg::PCT_FULL)) begin
            clamped = bse_pkg::PCT_FULL;
        end else begin
            clamped = whole[bse_pkg::PCT_W-1:0];
        end
        fit_pct = (r_job.op == bse_pkg::OP_FULL) ? bse_pkg::PCT_FULL : clamped;

        n_kept                   = r_kept;
        n_out.fitted_percent     = fit_pct;
        n_out.battery_millivolts = r_job.millivolts;
        n_out.store_request      = 1'b0;
        unique case (r_job.op)
            bse_pkg::OP_RESTORE: begin
                n_kept                   = r_job.percent;
                n_out.fitted_percent     = '0;
                n_out.battery_millivolts = '0;
            end
            bse_pkg::OP_DISCHARGE: begin
                if (r_kept > fit_pct) begin
                    n_kept              = fit_pct;
                    n_out.store_request = 1'b1;
                end
            end
            bse_pkg::OP_CHARGE, bse_pkg::OP_FULL: begin
                if (r_kept < fit_pct) begin
                    n_kept              = fit_pct;
                    n_out.store_request = 1'b1;
                end
            end
            default: n_kept = r_kept;
        endcase
        n_out.charge_percent = n_kept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bse_pkg::BS_IDLE;
            r_out_valid <= 1'b0;
            r_kept      <= '0;
            r_chunk     <= '0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_kept      <= n_kept;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_chunk <= '0;
                r_step  <= '0;
            end else if (r_state == bse_pkg::BS_MUL) begin
                if (chunk_last) begin
                    r_chunk <= '0;
                    r_step  <= r_step + 2'd1;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_acc  <= bse_pkg::FIT_COEF[load_fit][0];
            r_prod <= bse_pkg::FIT_COEF[load_fit][1];
        end else if (r_state == bse_pkg::BS_MUL) begin
            if (chunk_last) begin
                r_acc  <= n_sum;
                r_prod <= bse_pkg::FIT_COEF[run_fit][coef_idx];
            end else begin
                r_prod <= n_sum;
            end
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

endmodule

### hw/rtl/battery_soc_estimator.sv
// Battery state-of-charge estimator, top level. An accepted item is registered in the front end,
// queued, and taken by the fit engine, which loads its word into the output register; restore and
// fully-charged words skip the Horner steps. The fit engine runs 3 Horner steps of 3 multiplier
// passes each, and takes no new job until the word of the last one is loaded. Synchronous
// active-low reset sets the scale to 2.0, the kept charge to 0 and empties the queue and output
// register. Instantiates bse_front, bse_queue and bse_back; uses bse_pkg.
module battery_soc_estimator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bse_pkg::SCALE_W-1:0]  i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  bse_pkg::t_in_item            i_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output bse_pkg::t_out_item           o_data
);

    bse_pkg::t_queue_status qstat;
    bse_pkg::t_job          push_job;
    bse_pkg::t_job          head_job;
    logic                   push;
    logic                   pop;

    bse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_job       (push_job)
    );

    bse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    bse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule
